[rtl/tedr_pkg.sv]
// shared types and constants for the trie edit distance row block
`timescale 1ns / 1ps
`default_nettype none

package tedr_pkg;

	localparam int DIST_W  = 7;
	localparam int CHAR_W  = 8;
	localparam int DEPTH_W = 6;
	localparam int QLEN_W  = 5;
	localparam int NQCHARS = 16;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 64;

	localparam int DEF_MAX_QUERY_LEN  = 16;
	localparam int DEF_MAX_WORD_DEPTH = 32;

	localparam logic [DIST_W-1:0] DIST_SAT = 7'd127;

	typedef enum logic [1:0] {
		REG_QCHARS_LO = 2'd0,
		REG_QCHARS_HI = 2'd1,
		REG_QLEN      = 2'd2,
		REG_LIMIT     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [NQCHARS-1:0][CHAR_W-1:0] qchars;
		logic [QLEN_W-1:0]              qlen;
		logic [DIST_W-1:0]              limit;
	} tedr_cfg_t;

	typedef struct packed {
		logic              fire;
		logic              match;
		logic              trans;
		logic [DIST_W-1:0] left;
		logic [DIST_W-1:0] up;
		logic [DIST_W-1:0] diag;
		logic [DIST_W-1:0] diag2;
		logic [DIST_W-1:0] min_in;
	} tedr_cell_in_t;

	typedef struct packed {
		logic              tok;
		logic [DIST_W-1:0] val;
		logic [DIST_W-1:0] rmin;
	} tedr_cell_out_t;

endpackage

`default_nettype wire

[rtl/trie_edit_distance_row.sv]
// top level: row store and a chain of column cells for one trie row
//
// channel   direction  handshake                    payload
// command   in         start, busy                  depth, new_char, parent_char, is_word
// result    out        done (one-cycle strobe)      distance, is_match, descend
// config    in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// an in-range depth reads the row store at the accepting edge; the token then runs down the
// cell chain one column per cycle, and the result is registered and the row written as done
// rises; busy drops as done rises, so a transaction is accepted only after the last one ends
// an out-of-range depth gives its result in the cycle after accept and never raises busy
// row 0 is built in, so no clearing pass follows reset; done lasts one cycle, never held off
`timescale 1ns / 1ps
`default_nettype none

module trie_edit_distance_row #(
	parameter int MAX_QUERY_LEN  = tedr_pkg::DEF_MAX_QUERY_LEN,
	parameter int MAX_WORD_DEPTH = tedr_pkg::DEF_MAX_WORD_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tedr_pkg::DEPTH_W-1:0]  depth,
	input  logic [tedr_pkg::CHAR_W-1:0]   new_char,
	input  logic [tedr_pkg::CHAR_W-1:0]   parent_char,
	input  logic                          is_word,
	output logic                          done,
	output logic [tedr_pkg::DIST_W-1:0]   distance,
	output logic                          is_match,
	output logic                          descend,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tedr_pkg::APB_AW-1:0]   paddr,
	input  logic [tedr_pkg::APB_DW-1:0]   pwdata,
	output logic [tedr_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import tedr_pkg::*;

	localparam int NCOL   = MAX_QUERY_LEN + 1;
	localparam int COL_W  = $clog2(NCOL);
	localparam int ROW_AW = $clog2(MAX_WORD_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	tedr_cfg_t cfg;

	tedr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	state_t state_q;
	logic   first_q, done_q;

	logic [CHAR_W-1:0] new_char_q, parent_char_q;
	logic              is_word_q, not_depth1_q, prev_zero_q, prev2_zero_q;
	logic [ROW_AW-1:0] wr_addr_q;
	logic [DIST_W-1:0] distance_q;
	logic              is_match_q, descend_q;

	logic [NCOL-1:0][DIST_W-1:0] row_mem [MAX_WORD_DEPTH+1];
	logic [NCOL-1:0][DIST_W-1:0] prev_raw_q, prev2_raw_q;
	logic [NCOL-1:0][DIST_W-1:0] prev_row, prev2_row, cur_row;
	logic [NCOL-1:0]             col_on, tok_v;

	logic              accept, depth_ok, accept_ok, accept_bad, fin;
	logic [ROW_AW-1:0] rd_addr1, rd_addr2;
	logic [COL_W-1:0]  len_c;
	logic              tok_sel;
	logic [DIST_W-1:0] dist_sel, rmin_sel;

	tedr_cell_out_t cout [NCOL];

	assign busy       = (state_q == ST_RUN);
	assign accept     = start && !busy;
	assign depth_ok   = (depth != '0) && (7'(depth) <= 7'(MAX_WORD_DEPTH));
	assign accept_ok  = accept && depth_ok;
	assign accept_bad = accept && !depth_ok;

	assign rd_addr1 = ROW_AW'(depth) - ROW_AW'(1);
	assign rd_addr2 = (depth >= DEPTH_W'(2)) ? ROW_AW'(depth) - ROW_AW'(2) : '0;

	assign len_c = (cfg.qlen > QLEN_W'(MAX_QUERY_LEN)) ? COL_W'(MAX_QUERY_LEN)
	                                                   : COL_W'(cfg.qlen);

	// row 0 is never written; its column-index contents are substituted here
	always_comb begin
		for (int i = 0; i < NCOL; i++) begin
			prev_row[i]  = prev_zero_q  ? DIST_W'(i) : prev_raw_q[i];
			prev2_row[i] = prev2_zero_q ? DIST_W'(i) : prev2_raw_q[i];
		end
	end

	genvar c;
	generate
		for (c = 0; c < NCOL; c++) begin : g_col
			tedr_cell_in_t ci;

			assign col_on[c]  = (COL_W'(c) <= len_c);
			assign tok_v[c]   = cout[c].tok;
			assign cur_row[c] = cout[c].val;

			if (c == 0) begin : g_first
				always_comb begin
					ci        = '0;
					ci.fire   = first_q;
					ci.up     = prev_row[0];
					ci.left   = DIST_SAT;
					ci.diag   = DIST_SAT;
					ci.diag2  = DIST_SAT;
					ci.min_in = DIST_SAT;
				end
			end else begin : g_rest
				logic tr;
				if (c >= 2) begin : g_tr
					assign tr = not_depth1_q && (new_char_q == cfg.qchars[c-2])
					         && (parent_char_q == cfg.qchars[c-1])
					         && (cfg.qchars[c-1] != new_char_q);
					assign ci.diag2 = prev2_row[c-2];
				end else begin : g_notr
					assign tr       = 1'b0;
					assign ci.diag2 = DIST_SAT;
				end
				assign ci.fire   = cout[c-1].tok && col_on[c];
				assign ci.match  = (cfg.qchars[c-1] == new_char_q);
				assign ci.trans  = tr;
				assign ci.left   = cout[c-1].val;
				assign ci.up     = prev_row[c];
				assign ci.diag   = prev_row[c-1];
				assign ci.min_in = cout[c-1].rmin;
			end

			tedr_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.cin    (ci),
				.cout   (cout[c])
			);
		end
	endgenerate

	assign tok_sel  = cout[len_c].tok;
	assign dist_sel = cout[len_c].val;
	assign rmin_sel = cout[len_c].rmin;
	assign fin      = (state_q == ST_RUN) && tok_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			first_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			first_q <= accept_ok;
			done_q  <= accept_bad || fin;
			unique case (state_q)
				ST_IDLE: begin
					if (accept_ok) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (fin) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_ok) begin
			new_char_q    <= new_char;
			parent_char_q <= parent_char;
			is_word_q     <= is_word;
			not_depth1_q  <= (depth != DEPTH_W'(1));
			prev_zero_q   <= (depth == DEPTH_W'(1));
			prev2_zero_q  <= (depth == DEPTH_W'(2));
			wr_addr_q     <= ROW_AW'(depth);
		end
		priority if (accept_bad) begin
			distance_q <= DIST_SAT;
			is_match_q <= 1'b0;
			descend_q  <= 1'b0;
		end else if (fin) begin
			distance_q <= dist_sel;
			is_match_q <= is_word_q && (dist_sel <= cfg.limit);
			descend_q  <= (rmin_sel <= cfg.limit);
		end
	end

	// row store: two reads at accept, masked write of the finished row
	always_ff @(posedge clk) begin
		if (accept_ok) begin
			prev_raw_q  <= row_mem[rd_addr1];
			prev2_raw_q <= row_mem[rd_addr2];
		end
		if (fin) begin
			for (int i = 0; i < NCOL; i++) begin
				if (col_on[i]) row_mem[wr_addr_q][i] <= cur_row[i];
			end
		end
	end

	assign done     = done_q;
	assign distance = distance_q;
	assign is_match = is_match_q;
	assign descend  = descend_q;

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(fin) || $past(accept_bad)))
		else $error("result strobe without a finished transaction");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_v))
		else $error("more than one token in the cell chain");

	a_first_run: assert property (@(posedge clk) disable iff (!arst_n)
		first_q |-> (state_q == ST_RUN))
		else $error("chain launched outside a row computation");

	a_accept_run: assert property (@(posedge clk) disable iff (!arst_n)
		accept_ok |=> (busy && first_q && !done_q))
		else $error("accepted transaction did not start the chain");

endmodule

`default_nettype wire

[rtl/tedr_cell.sv]
// one column cell of the alignment row chain
`timescale 1ns / 1ps
`default_nettype none

module tedr_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tedr_pkg::tedr_cell_in_t cin,
	output tedr_pkg::tedr_cell_out_t cout
);
	import tedr_pkg::*;

	function automatic logic [DIST_W-1:0] inc_sat(input logic [DIST_W-1:0] v);
		inc_sat = (v == DIST_SAT) ? DIST_SAT : v + 1'b1;
	endfunction

	logic [DIST_W-1:0] c_left, c_up, c_sub, c_tr, m0, m1, v;
	logic              tok_q;
	logic [DIST_W-1:0] val_q, rmin_q;

	always_comb begin
		c_left = inc_sat(cin.left);
		c_up   = inc_sat(cin.up);
		c_sub  = cin.match ? cin.diag : inc_sat(cin.diag);
		c_tr   = cin.trans ? inc_sat(cin.diag2) : DIST_SAT;
		m0     = (c_left < c_up) ? c_left : c_up;
		m1     = (c_sub < c_tr) ? c_sub : c_tr;
		v      = (m0 < m1) ? m0 : m1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= cin.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (cin.fire) begin
			val_q  <= v;
			rmin_q <= (v < cin.min_in) ? v : cin.min_in;
		end
	end

	assign cout.tok  = tok_q;
	assign cout.val  = val_q;
	assign cout.rmin = rmin_q;

endmodule

`default_nettype wire

[rtl/tedr_cfg.sv]
// apb configuration registers: query characters, query length, distance limit
`timescale 1ns / 1ps
`default_nettype none

module tedr_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tedr_pkg::APB_AW-1:0]     paddr,
	input  logic [tedr_pkg::APB_DW-1:0]     pwdata,
	output logic [tedr_pkg::APB_DW-1:0]     prdata,
	output tedr_pkg::tedr_cfg_t             cfg
);
	import tedr_pkg::*;

	tedr_cfg_t cfg_q;
	reg_idx_t  idx;
	logic      wr;

	assign idx = reg_idx_t'(paddr[APB_AW-1:3]);
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_QCHARS_LO: cfg_q.qchars[7:0]  <= pwdata;
				REG_QCHARS_HI: cfg_q.qchars[15:8] <= pwdata;
				REG_QLEN:      cfg_q.qlen         <= pwdata[QLEN_W-1:0];
				REG_LIMIT:     cfg_q.limit        <= pwdata[DIST_W-1:0];
				default:       cfg_q              <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_QCHARS_LO: prdata = cfg_q.qchars[7:0];
			REG_QCHARS_HI: prdata = cfg_q.qchars[15:8];
			REG_QLEN:      prdata = APB_DW'(cfg_q.qlen);
			REG_LIMIT:     prdata = APB_DW'(cfg_q.limit);
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for the trie edit distance row block
`timescale 1ns / 1ps

module testbench;
	import tedr_pkg::*;

	localparam int QMAX = DEF_MAX_QUERY_LEN;
	localparam int DMAX = DEF_MAX_WORD_DEPTH;

	typedef struct packed {
		logic [DIST_W-1:0] dval;
		logic              match;
		logic              desc;
	} row_result_t;

	typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

	typedef struct packed {
		step_kind_t         kind;
		reg_idx_t           idx;
		logic [63:0]        value;
		logic [DEPTH_W-1:0] d;
		logic [CHAR_W-1:0]  nc;
		logic [CHAR_W-1:0]  pc;
		logic               w;
		logic               fixed;
		row_result_t        want;
	} plan_step_t;

	// query "cat" + 0x00 + 0xff ..., then walks over "act", "ca" and a few extremes
	localparam plan_step_t DIRECTED [0:24] = '{
		'{STEP_ITEM, REG_QCHARS_LO, 64'h0, 6'd1, 8'h78, 8'h00, 1'b1, 1'b1, '{7'd1, 1'b0, 1'b0}},
		'{STEP_ITEM, REG_QCHARS_LO, 64'h0, 6'd0, 8'hFF, 8'hFF, 1'b1, 1'b1, '{7'd127, 1'b0, 1'b0}},
		'{STEP_ITEM, REG_QCHARS_LO, 64'h0, 6'd33, 8'h00, 8'hFF, 1'b1, 1'b1, '{7'd127, 1'b0, 1'b0}},
		'{STEP_ITEM, REG_QCHARS_LO, 64'h0, 6'd63, 8'h5A, 8'hA5, 1'b0, 1'b1, '{7'd127, 1'b0, 1'b0}},
		'{STEP_CFG, REG_QCHARS_LO, 64'hFF6B_73FF_0074_6163, 6'd0, 8'h0, 8'h0, 1'b0, 1'b0, '0},
		'{STEP_CFG, REG_QCHARS_HI, 64'h7A79_7877_0000_FFFF, 6'd0, 8'h0, 8'h0, 1'b0, 1'b0, '0},
		'{STEP_CFG, REG_QLEN, 64'd4, 6'd0, 8'h0, 8'h0, 1'b0, 1'b0, '0},
		'{STEP_CFG, REG_LIMIT, 64'd1, 6'd0, 8'h0, 8'h0, 1'b0, 1'b0, '0},
		'{STEP_ITEM, REG_QCHARS_LO, 64'h0, 6'd1, 8'h61, 8'h63, 1'b0, 1'b0, '0},
		'{STEP_ITEM, REG_QCHARS_LO, 64'h0, 6'd2, 8'h63, 8'h61, 1'b0, 1'b0, '0},
		'{STEP_ITEM, REG_QCHARS_LO, 64'h0, 6'd3, 8'h74, 8'h63, 1'b0, 1'b0, '0},
		'{STEP_ITEM, REG_QCHARS_LO, 64'h0, 6'd4, 8'h00, 8'h74, 1'b1, 1'b0, '0},
		'{STEP_ITEM, REG_QCHARS_LO, 64'h0, 6'd2, 8'h61, 8'h63, 1'b1, 1'b0, '0},
		'{STEP_CFG, REG_QLEN, 64'd16, 6'd0, 8'h0, 8'h0, 1'b0, 1'b0, '0},
		'{STEP_CFG, REG_LIMIT, 64'd127, 6'd0, 8'h0, 8'h0, 1'b0, 1'b0, '0},
		'{STEP_ITEM, REG_QCHARS_LO, 64'h0, 6'd1, 8'h63, 8'hFF, 1'b1, 1'b0, '0},
		'{STEP_ITEM, REG_QCHARS_LO, 64'h0, 6'd2, 8'hFF, 8'h63, 1'b0, 1'b0, '0},
		'{STEP_ITEM, REG_QCHARS_LO, 64'h0, 6'd3, 8'h00, 8'hFF, 1'b1, 1'b0, '0},
		'{STEP_CFG, REG_QLEN, 64'd31, 6'd0, 8'h0, 8'h0, 1'b0, 1'b0, '0},
		'{STEP_CFG, REG_LIMIT, 64'd0, 6'd0, 8'h0, 8'h0, 1'b0, 1'b0, '0},
		'{STEP_ITEM, REG_QCHARS_LO, 64'h0, 6'd1, 8'h63, 8'h00, 1'b1, 1'b0, '0},
		'{STEP_ITEM, REG_QCHARS_LO, 64'h0, 6'd2, 8'h61, 8'h63, 1'b1, 1'b0, '0},
		'{STEP_CFG, REG_QLEN, 64'd0, 6'd0, 8'h0, 8'h0, 1'b0, 1'b0, '0},
		'{STEP_CFG, REG_LIMIT, 64'd127, 6'd0, 8'h0, 8'h0, 1'b0, 1'b0, '0},
		'{STEP_ITEM, REG_QCHARS_LO, 64'h0, 6'd1, 8'h55, 8'hAA, 1'b1, 1'b1, '{7'd1, 1'b1, 1'b1}}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [DEPTH_W-1:0]   depth = '0;
	logic [CHAR_W-1:0]    new_char = '0;
	logic [CHAR_W-1:0]    parent_char = '0;
	logic                 is_word = 1'b0;
	logic                 done;
	logic [DIST_W-1:0]    distance;
	logic                 is_match;
	logic                 descend;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [APB_AW-1:0]    paddr = '0;
	logic [APB_DW-1:0]    pwdata = '0;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	trie_edit_distance_row DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.depth(depth), .new_char(new_char), .parent_char(parent_char), .is_word(is_word),
		.done(done), .distance(distance), .is_match(is_match), .descend(descend),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// shadow of the block's configuration and row store
	logic [63:0]       q_lo = '0;
	logic [63:0]       q_hi = '0;
	logic [QLEN_W-1:0] q_len = '0;
	logic [DIST_W-1:0] lim = '0;
	logic [DIST_W-1:0] trie_rows [0:DMAX][0:QMAX];
	bit                row_cell_set [0:DMAX][0:QMAX];

	row_result_t rows_due [$];
	int          errors = 0;

	initial begin
		for (int r = 0; r <= DMAX; r++) begin
			for (int c = 0; c <= QMAX; c++) begin
				trie_rows[r][c] = (r == 0) ? c[DIST_W-1:0] : '0;
				row_cell_set[r][c] = (r == 0);
			end
		end
	end

	task automatic flag_mismatch(input string what);
		if (errors < 40) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
		errors++;
	endtask

	function automatic logic [CHAR_W-1:0] q_byte(input int i);
		if (i < 8) begin
			return q_lo[8*i +: 8];
		end else if (i < 16) begin
			return q_hi[8*(i-8) +: 8];
		end
		return '0;
	endfunction

	function automatic logic [DIST_W-1:0] dist_inc(input logic [DIST_W-1:0] v);
		return (v >= DIST_SAT) ? DIST_SAT : v + 1'b1;
	endfunction

	function automatic int eff_len();
		return (q_len > QMAX) ? QMAX : int'(q_len);
	endfunction

	// a row may only be computed from cells written since reset
	function automatic bit row_ok(input int d);
		int len;
		len = eff_len();
		for (int c = 0; c <= len; c++) begin
			if (!row_cell_set[d-1][c] || !row_cell_set[(d >= 2) ? d-2 : 0][c]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic row_result_t next_trie_row(input logic [DEPTH_W-1:0] d,
			input logic [CHAR_W-1:0] nc, input logic [CHAR_W-1:0] pc, input logic w);
		row_result_t       res;
		int                len;
		logic [DIST_W-1:0] v;
		logic [DIST_W-1:0] sub;
		logic [DIST_W-1:0] rmin;
		logic [CHAR_W-1:0] qc;
		res = '{DIST_SAT, 1'b0, 1'b0};
		if (d == 0 || d > DMAX) begin
			return res;
		end
		len = eff_len();
		trie_rows[d][0] = dist_inc(trie_rows[d-1][0]);
		row_cell_set[d][0] = 1'b1;
		rmin = trie_rows[d][0];
		for (int c = 1; c <= len; c++) begin
			qc = q_byte(c - 1);
			v = dist_inc(trie_rows[d][c-1]);
			sub = (qc == nc) ? trie_rows[d-1][c-1] : dist_inc(trie_rows[d-1][c-1]);
			if (dist_inc(trie_rows[d-1][c]) < v) v = dist_inc(trie_rows[d-1][c]);
			if (sub < v) v = sub;
			// adjacent swap of the last two prefix characters
			if (d != 1 && c > 1 && nc == q_byte(c - 2) && pc == qc && qc != nc) begin
				if (dist_inc(trie_rows[d-2][c-2]) < v) v = dist_inc(trie_rows[d-2][c-2]);
			end
			trie_rows[d][c] = v;
			row_cell_set[d][c] = 1'b1;
			if (v < rmin) rmin = v;
		end
		res.dval = trie_rows[d][len];
		res.match = w && (res.dval <= lim);
		res.desc = (rmin <= lim);
		return res;
	endfunction

	task automatic cfg_write(input reg_idx_t idx, input logic [63:0] val);
		logic [63:0] readback;
		case (idx)
			REG_QCHARS_LO: begin
				q_lo = val;
				readback = val;
			end
			REG_QCHARS_HI: begin
				q_hi = val;
				readback = val;
			end
			REG_QLEN: begin
				q_len = val[QLEN_W-1:0];
				readback = {59'd0, val[QLEN_W-1:0]};
			end
			default: begin
				lim = val[DIST_W-1:0];
				readback = {57'd0, val[DIST_W-1:0]};
			end
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== readback) begin
			flag_mismatch($sformatf("register %s reads %h, wrote %h", idx.name(), prdata, readback));
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_item(input logic [DEPTH_W-1:0] d, input logic [CHAR_W-1:0] nc,
			input logic [CHAR_W-1:0] pc, input logic w, input logic fixed, input row_result_t want);
		row_result_t predicted;
		start <= 1'b1;
		depth <= d;
		new_char <= nc;
		parent_char <= pc;
		is_word <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		predicted = next_trie_row(d, nc, pc, w);
		rows_due.insert(rows_due.size(), fixed ? want : predicted);
	endtask

	task automatic sender_gap(input int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// no transaction in flight, then a wait for the row write to land
	task automatic drain_results();
		start <= 1'b0;
		while (rows_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin : check_results
		row_result_t want;
		if (arst_n && done) begin
			if (rows_due.size() == 0) begin
				flag_mismatch("result strobe with no transaction pending");
			end else begin
				want = rows_due.pop_front();
				if (distance !== want.dval)
					flag_mismatch($sformatf("distance %0d, want %0d", distance, want.dval));
				if (is_match !== want.match)
					flag_mismatch($sformatf("is_match %b, want %b", is_match, want.match));
				if (descend !== want.desc)
					flag_mismatch($sformatf("descend %b, want %b", descend, want.desc));
			end
		end
	end

	initial begin : stimulus
		int                d;
		int                cur_depth;
		int                len_e;
		int                idx;
		int                gap_pct;
		int                spins;
		logic [CHAR_W-1:0] nc;
		logic [CHAR_W-1:0] pc;
		logic              w;
		logic [63:0]       lo;
		logic [63:0]       hi;
		logic [CHAR_W-1:0] path [0:DMAX];
		for (int k = 0; k <= DMAX; k++) path[k] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == STEP_CFG) begin
				drain_results();
				cfg_write(DIRECTED[i].idx, DIRECTED[i].value);
			end else begin
				send_item(DIRECTED[i].d, DIRECTED[i].nc, DIRECTED[i].pc, DIRECTED[i].w,
					DIRECTED[i].fixed, DIRECTED[i].want);
				sender_gap(30);
			end
		end

		for (int p = 0; p < 6; p++) begin
			if (p % 2 == 0) begin
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
			end else begin
				// few distinct letters so that matches and swaps are common
				for (int b = 0; b < 8; b++) begin
					lo[8*b +: 8] = 8'h61 + 8'($urandom_range(0, 3));
					hi[8*b +: 8] = 8'h61 + 8'($urandom_range(0, 3));
				end
			end
			drain_results();
			cfg_write(REG_QCHARS_LO, lo);
			cfg_write(REG_QCHARS_HI, hi);
			if (p == 5) begin
				cfg_write(REG_QLEN, 64'd16);
			end else if ($urandom_range(0, 7) == 0) begin
				cfg_write(REG_QLEN, 64'($urandom_range(17, 31)));
			end else begin
				cfg_write(REG_QLEN, 64'($urandom_range(0, 16)));
			end
			cfg_write(REG_LIMIT, ($urandom_range(0, 3) == 0) ? 64'd127
			                                                 : 64'($urandom_range(0, 6)));
			gap_pct = (p == 5) ? 0 : 30 * $urandom_range(0, 2);
			cur_depth = 0;

			for (int n = 0; n < 125; n++) begin
				if (p == 2 && n == 60) drain_results();
				len_e = eff_len();
				w = ($urandom_range(0, 2) == 0);
				if (!(p == 0 && n < DMAX) && $urandom_range(0, 9) == 0) begin
					// noise: out-of-range depth or arbitrary characters
					if ($urandom_range(0, 1) == 0) begin
						d = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(DMAX + 1, 63);
					end else begin
						d = $urandom_range(1, DMAX);
						if (!row_ok(d)) d = 1;
					end
					nc = 8'($urandom_range(0, 255));
					pc = 8'($urandom_range(0, 255));
				end else begin
					// trie walk: mostly go one level down, else back up to a sibling
					if (p == 0 && n < DMAX) begin
						d = n + 1;
					end else if (cur_depth < DMAX && $urandom_range(0, 9) < 6) begin
						d = cur_depth + 1;
					end else begin
						d = $urandom_range(1, (cur_depth < 1) ? 1 : cur_depth);
					end
					if (!row_ok(d)) d = 1;
					idx = $urandom_range(0, 9);
					if (len_e > 0 && idx < 5) begin
						idx = d - 2 + $urandom_range(0, 2);
						if (idx >= len_e) idx = len_e - 1;
						if (idx < 0) idx = 0;
						nc = q_byte(idx);
					end else if (len_e > 0 && idx < 7) begin
						nc = q_byte($urandom_range(0, len_e - 1));
					end else begin
						nc = 8'($urandom_range(0, 255));
					end
					pc = (d >= 2) ? path[d-1] : 8'($urandom_range(0, 255));
					path[d] = nc;
					cur_depth = d;
				end
				send_item(DEPTH_W'(d), nc, pc, w, 1'b0, '0);
				sender_gap(gap_pct);
			end
		end

		start <= 1'b0;
		spins = 0;
		while (rows_due.size() != 0 && spins < 2000) begin
			@(posedge clk);
			spins++;
		end
		repeat (25) @(posedge clk);
		if (rows_due.size() != 0) begin
			flag_mismatch($sformatf("%0d results never arrived", rows_due.size()));
		end
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin : watchdog
		#500000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
rtl/tedr_pkg.sv
rtl/tedr_cell.sv
rtl/tedr_cfg.sv
rtl/trie_edit_distance_row.sv
tb/testbench.sv
